@@ design/slcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types and constants for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

  localparam int unsigned LengthLimit = 50;
  localparam int unsigned CntW        = 6;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 16;
  localparam int unsigned AccW        = 40;
  localparam int unsigned CoordBytes  = 4;

  localparam logic [ByteW-1:0] Sync1Byte = 8'hFF;
  localparam logic [ByteW-1:0] Sync2Byte = 8'hFC;
  localparam logic [ByteW-1:0] IdBad     = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEAD2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_e;

  // frame result from the parser, valid on the checksum byte
  typedef struct packed {
    logic                   done;
    status_e                status;
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
  } frame_res_t;

endpackage

@@ design/sync_length_checksum_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser
// Parses FF FC id len payload checksum frames, one byte per transfer.
// ----------------------------------------------------------------------------
// output: a frame result is registered and shown on the output in the
//   cycle after its checksum byte transfer
// throughput: one byte per cycle; input stalls only when a checksum byte
//   arrives while the previous result is still held in the output register
// reset: rst_ni asynchronous active low clears the parser state, the enable
//   register, both running sums and the output valid
module sync_length_checksum_frame_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  // byte input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [slcfp_pkg::ByteW-1:0]           rx_byte_i,
  // frame result
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            frame_status_o,
  output logic signed [slcfp_pkg::PosW-1:0]     x_position_o,
  output logic signed [slcfp_pkg::PosW-1:0]     y_position_o,
  output logic signed [slcfp_pkg::AccW-1:0]     x_total_o,
  output logic signed [slcfp_pkg::AccW-1:0]     y_total_o
);

  logic                              in_fire;
  logic                              at_check;
  logic                              res_fire;
  logic                              out_valid_q, out_valid_d;
  slcfp_pkg::frame_res_t             res;
  logic signed [slcfp_pkg::AccW-1:0] x_tot_d, y_tot_d;
  logic [1:0]                        status_q;
  logic signed [slcfp_pkg::PosW-1:0] x_pos_q, y_pos_q;
  logic signed [slcfp_pkg::AccW-1:0] x_tot_q, y_tot_q;

  // only the checksum byte makes a result, so other bytes flow freely
  // even while the output register is stalled
  assign in_ready_o = !(at_check && out_valid_q && !out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_fire   = in_fire && res.done;

  slcfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .rx_byte_i  (rx_byte_i),
    .at_check_o (at_check),
    .res_o      (res)
  );

  slcfp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .res_i       (res),
    .x_total_o   (x_tot_d),
    .y_total_o   (y_tot_d)
  );

  // output register: load on a new result, drop on transfer out
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      status_q <= res.status;
      x_pos_q  <= res.x_pos;
      y_pos_q  <= res.y_pos;
      x_tot_q  <= x_tot_d;
      y_tot_q  <= y_tot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign x_position_o   = x_pos_q;
  assign y_position_o   = y_pos_q;
  assign x_total_o      = x_tot_q;
  assign y_total_o      = y_tot_q;

endmodule

@@ design/slcfp_parser.sv @@
// ----------------------------------------------------------------------------
// slcfp_parser
// Byte-wise frame state machine: sync, id, length, payload, checksum.
// ----------------------------------------------------------------------------
module slcfp_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic [slcfp_pkg::ByteW-1:0]      rx_byte_i,
  output logic                             at_check_o,
  output slcfp_pkg::frame_res_t            res_o
);

  slcfp_pkg::phase_e                phase_q, phase_d;
  logic [slcfp_pkg::CntW-1:0]       left_q, left_d;
  logic [slcfp_pkg::CntW-1:0]       seen_q, seen_d;
  logic [slcfp_pkg::ByteW-1:0]      sum_q, sum_d;
  logic [slcfp_pkg::ByteW-1:0]      coord_q [slcfp_pkg::CoordBytes];
  logic                             coord_we;
  logic [slcfp_pkg::PosW-1:0]       raw_x, raw_y;
  logic [slcfp_pkg::ByteW-1:0]      sum_add;
  logic [slcfp_pkg::CntW-1:0]       left_dec;

  assign sum_add  = sum_q + rx_byte_i;
  assign left_dec = left_q - 1'b1;
  assign raw_x    = {coord_q[0], coord_q[1]};
  assign raw_y    = {coord_q[2], coord_q[3]};
  assign at_check_o = (phase_q == slcfp_pkg::PH_CHECK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slcfp_pkg::PH_IDLE;
      left_q  <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
    end
  end

  // first four payload bytes hold the coordinates
  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_q[seen_q[1:0]] <= rx_byte_i;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    coord_we = 1'b0;
    res_o    = '{done: 1'b0, status: slcfp_pkg::STATUS_GOOD, x_pos: '0, y_pos: '0};
    case (phase_q)
      slcfp_pkg::PH_IDLE: begin
        if (rx_byte_i == slcfp_pkg::Sync1Byte) begin
          phase_d = slcfp_pkg::PH_HEAD2;
          sum_d   = rx_byte_i;
        end
      end
      slcfp_pkg::PH_HEAD2: begin
        if (rx_byte_i == slcfp_pkg::Sync2Byte) begin
          phase_d = slcfp_pkg::PH_ID;
          sum_d   = sum_add;
        end else begin
          phase_d = slcfp_pkg::PH_IDLE;
        end
      end
      slcfp_pkg::PH_ID: begin
        if (rx_byte_i != slcfp_pkg::IdBad) begin
          phase_d = slcfp_pkg::PH_LEN;
          sum_d   = sum_add;
        end else begin
          phase_d = slcfp_pkg::PH_IDLE;
        end
      end
      slcfp_pkg::PH_LEN: begin
        if (rx_byte_i != '0 &&
            rx_byte_i < slcfp_pkg::ByteW'(slcfp_pkg::LengthLimit)) begin
          phase_d = slcfp_pkg::PH_PAYLOAD;
          left_d  = rx_byte_i[slcfp_pkg::CntW-1:0];
          seen_d  = '0;
          sum_d   = sum_add;
        end else begin
          phase_d = slcfp_pkg::PH_IDLE;
        end
      end
      slcfp_pkg::PH_PAYLOAD: begin
        coord_we = fire_i && (seen_q < slcfp_pkg::CntW'(slcfp_pkg::CoordBytes));
        seen_d   = seen_q + 1'b1;
        sum_d    = sum_add;
        left_d   = left_dec;
        if (left_dec == '0) begin
          phase_d = slcfp_pkg::PH_CHECK;
        end
      end
      slcfp_pkg::PH_CHECK: begin
        phase_d    = slcfp_pkg::PH_IDLE;
        res_o.done = 1'b1;
        if (rx_byte_i != sum_q) begin
          res_o.status = slcfp_pkg::STATUS_BAD_SUM;
        end else if (seen_q < slcfp_pkg::CntW'(slcfp_pkg::CoordBytes)) begin
          res_o.status = slcfp_pkg::STATUS_SHORT;
        end else begin
          res_o.status = slcfp_pkg::STATUS_GOOD;
          res_o.x_pos  = $signed(16'd0 - raw_x);
          res_o.y_pos  = $signed(raw_y);
        end
      end
      default: begin
        phase_d = slcfp_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

@@ design/slcfp_accum.sv @@
// ----------------------------------------------------------------------------
// slcfp_accum
// Enable register and 40-bit saturating running sums of good-frame coordinates.
// ----------------------------------------------------------------------------
module slcfp_accum (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_wdata_i,
  input  logic                                   fire_i,
  input  slcfp_pkg::frame_res_t                  res_i,
  output logic signed [slcfp_pkg::AccW-1:0]      x_total_o,
  output logic signed [slcfp_pkg::AccW-1:0]      y_total_o
);

  localparam logic signed [slcfp_pkg::AccW-1:0] AccMax = {1'b0, {(slcfp_pkg::AccW-1){1'b1}}};
  localparam logic signed [slcfp_pkg::AccW-1:0] AccMin = {1'b1, {(slcfp_pkg::AccW-1){1'b0}}};

  logic                              en_q;
  logic signed [slcfp_pkg::AccW-1:0] x_q, x_d, y_q, y_d;
  logic                              add_en;

  function automatic logic signed [slcfp_pkg::AccW-1:0] sat_add(
    input logic signed [slcfp_pkg::AccW-1:0] acc,
    input logic signed [slcfp_pkg::PosW-1:0] val
  );
    logic signed [slcfp_pkg::AccW:0] wide;
    wide = {acc[slcfp_pkg::AccW-1], acc} +
           {{(slcfp_pkg::AccW+1-slcfp_pkg::PosW){val[slcfp_pkg::PosW-1]}}, val};
    if (wide[slcfp_pkg::AccW] != wide[slcfp_pkg::AccW-1]) begin
      sat_add = wide[slcfp_pkg::AccW] ? AccMin : AccMax;
    end else begin
      sat_add = wide[slcfp_pkg::AccW-1:0];
    end
  endfunction

  assign add_en = fire_i && res_i.done && en_q && (res_i.status == slcfp_pkg::STATUS_GOOD);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (add_en) begin
      x_d = sat_add(x_q, res_i.x_pos);
      y_d = sat_add(y_q, res_i.y_pos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      x_q  <= '0;
      y_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // totals as they stand after this item
  assign x_total_o = x_d;
  assign y_total_o = y_d;

endmodule

@@ verif/sync_length_checksum_frame_parser_tb.sv @@
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser_tb
// Self-checking bench for the frame parser. Streams bytes made of good,
// corrupted, short, long and broken frames plus line noise, predicts each
// frame report with an in-bench parser model, and checks every report
// field by field under several handshake idling mixes and enable settings.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcfp_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int unsigned CycleLimit    = 200000;
  // quiet cycles after the last report, covers the output register stage
  localparam int unsigned DrainCycles   = 8;
  // long receiver hold-off so the output stage fills and backs up the input
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned BytesPerPhase = 390;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // one frame report as seen on the output channel
  typedef struct {
    status_e                status;
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
    logic signed [AccW-1:0] x_sum;
    logic signed [AccW-1:0] y_sum;
  } frame_report_t;

  // dut ports, the inputs all known from time zero
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_wdata_i = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [ByteW-1:0]       rx_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             frame_status_o;
  logic signed [PosW-1:0] x_position_o;
  logic signed [PosW-1:0] y_position_o;
  logic signed [AccW-1:0] x_total_o;
  logic signed [AccW-1:0] y_total_o;

  // bytes waiting to be offered, and reports waiting to come out
  logic [ByteW-1:0] tx_bytes[$];
  frame_report_t    pending_reports[$];
  int unsigned      tx_count = 0;

  // idling mix and hold-off control
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_armed     = 1'b0;
  logic        rx_hold        = 1'b0;

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  // parser model state, mirrors what the block should hold
  phase_e                 ps_phase = PH_IDLE;
  logic [CntW-1:0]        ps_left  = '0;
  logic [CntW-1:0]        ps_seen  = '0;
  logic [ByteW-1:0]       ps_sum   = '0;
  logic [ByteW-1:0]       ps_coord [CoordBytes];
  logic signed [AccW-1:0] ps_x_acc = '0;
  logic signed [AccW-1:0] ps_y_acc = '0;
  bit                     ps_acc_en = 1'b0;

  sync_length_checksum_frame_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .x_position_o   (x_position_o),
    .y_position_o   (y_position_o),
    .x_total_o      (x_total_o),
    .y_total_o      (y_total_o)
  );

  always #1 clk_i = ~clk_i;

  // 40-bit running sum that clips at the signed limits
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] acc,
                                                     input logic signed [PosW-1:0] v);
    logic signed [AccW:0] s;
    s = acc + v;
    if (s > AccMax) return AccMax;
    if (s < AccMin) return AccMin;
    return s[AccW-1:0];
  endfunction

  // advance the parser model by one byte; returns 1 when a report is due
  function automatic bit parse_byte(input logic [ByteW-1:0] b, output frame_report_t rep);
    logic [PosW-1:0] raw_x;
    logic [PosW-1:0] raw_y;
    rep.status = STATUS_GOOD;
    rep.x_pos  = '0;
    rep.y_pos  = '0;
    rep.x_sum  = '0;
    rep.y_sum  = '0;
    parse_byte = 1'b0;
    case (ps_phase)
      PH_IDLE: begin
        if (b == Sync1Byte) begin
          ps_phase = PH_HEAD2;
          ps_sum   = b;
        end
      end
      PH_HEAD2: begin
        // a repeated FF drops back to idle, no resync on it
        if (b == Sync2Byte) begin
          ps_phase = PH_ID;
          ps_sum   = ps_sum + b;
        end else begin
          ps_phase = PH_IDLE;
        end
      end
      PH_ID: begin
        if (b != IdBad) begin
          ps_phase = PH_LEN;
          ps_sum   = ps_sum + b;
        end else begin
          ps_phase = PH_IDLE;
        end
      end
      PH_LEN: begin
        // zero length and lengths at or over the limit abort
        if (b != '0 && b < LengthLimit) begin
          ps_phase = PH_PAYLOAD;
          ps_left  = b[CntW-1:0];
          ps_seen  = '0;
          ps_sum   = ps_sum + b;
        end else begin
          ps_phase = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        // only the leading coordinate bytes are kept, the rest just feed the sum
        if (ps_seen < CoordBytes) ps_coord[ps_seen[1:0]] = b;
        ps_seen = ps_seen + 1'b1;
        ps_sum  = ps_sum + b;
        ps_left = ps_left - 1'b1;
        if (ps_left == '0) ps_phase = PH_CHECK;
      end
      PH_CHECK: begin
        ps_phase   = PH_IDLE;
        parse_byte = 1'b1;
        // checksum is tested before the short payload test
        if (b != ps_sum) begin
          rep.status = STATUS_BAD_SUM;
        end else if (ps_seen < CoordBytes) begin
          rep.status = STATUS_SHORT;
        end else begin
          raw_x     = {ps_coord[0], ps_coord[1]};
          raw_y     = {ps_coord[2], ps_coord[3]};
          rep.x_pos = -raw_x;
          rep.y_pos = raw_y;
          if (ps_acc_en) begin
            ps_x_acc = sat_add(ps_x_acc, rep.x_pos);
            ps_y_acc = sat_add(ps_y_acc, rep.y_pos);
          end
        end
        rep.x_sum = ps_x_acc;
        rep.y_sum = ps_y_acc;
      end
      default: begin
        ps_phase = PH_IDLE;
      end
    endcase
  endfunction

  // byte sender: predicts on each accepted transfer, then offers the next byte
  always @(posedge clk_i) begin : byte_driver
    frame_report_t rep;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (parse_byte(rx_byte_i, rep)) pending_reports.push_back(rep);
      end
      // valid holds with the same byte until the transfer happens
      if (!in_valid_i || in_ready_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // report receiver and checker
  always @(posedge clk_i) begin : report_monitor
    frame_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("frame report with none expected, frame_status %0d", frame_status_o);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          if (frame_status_o !== want.status) begin
            $error("frame_status expected %0d got %0d", want.status, frame_status_o);
            err_count++;
          end
          if (x_position_o !== want.x_pos) begin
            $error("x_position expected %0d got %0d", want.x_pos, x_position_o);
            err_count++;
          end
          if (y_position_o !== want.y_pos) begin
            $error("y_position expected %0d got %0d", want.y_pos, y_position_o);
            err_count++;
          end
          if (x_total_o !== want.x_sum) begin
            $error("x_total expected %0d got %0d", want.x_sum, x_total_o);
            err_count++;
          end
          if (y_total_o !== want.y_sum) begin
            $error("y_total expected %0d got %0d", want.y_sum, y_total_o);
            err_count++;
          end
        end
      end
    end
  end

  // long receiver hold-off, counted here while the sender keeps going
  always begin : rx_holdoff
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
    hold_armed = 1'b0;
  end

  // hang guard
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sync_length_checksum_frame_parser_tb NOT OK");
      $finish;
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    tx_bytes.push_back(b);
    tx_count++;
  endtask

  // wait until every byte is sent and every report is back, then let it settle
  task automatic settle();
    while (tx_bytes.size() != 0 || in_valid_i || pending_reports.size() != 0 || hold_armed)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // only ever called with the block idle
  task automatic write_enable(input bit en);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ps_acc_en   = en;
  endtask

  // full frame; head gives the first payload bytes, msb first
  task automatic queue_frame(input logic [ByteW-1:0] id, input int unsigned len,
                             input logic [31:0] head, input bit bad_sum);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    sum = Sync1Byte + Sync2Byte + id + len[ByteW-1:0];
    push_byte(Sync1Byte);
    push_byte(Sync2Byte);
    push_byte(id);
    push_byte(len[ByteW-1:0]);
    for (int unsigned i = 0; i < len; i++) begin
      b = (i < CoordBytes) ? head[31 - 8*i -: 8] : 8'($urandom_range(255));
      push_byte(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  // coordinate word, biased toward the signed corners
  function automatic logic [PosW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // mostly well formed frames with random content, some broken ones and noise
  task automatic random_traffic(input int unsigned quota);
    int unsigned first_count;
    int unsigned pick;
    int unsigned len;
    first_count = tx_count;
    while (tx_count - first_count < quota) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        // small payloads dominate, a few run up to the limit
        len = $urandom_range(99);
        if (len < 10)      len = $urandom_range(1, 3);
        else if (len < 92) len = $urandom_range(4, 8);
        else               len = $urandom_range(9, LengthLimit - 1);
        queue_frame(8'($urandom_range(254)), len, {pick_coord(), pick_coord()},
                    $urandom_range(99) < 12);
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0: begin
            // bad second sync byte, often another FF
            push_byte(Sync1Byte);
            push_byte($urandom_range(1) ? Sync1Byte : 8'($urandom_range(255)));
          end
          1: begin
            push_byte(Sync1Byte);
            push_byte(Sync2Byte);
            push_byte(IdBad);
          end
          2: begin
            // length of zero, exactly the limit, or beyond
            push_byte(Sync1Byte);
            push_byte(Sync2Byte);
            push_byte(8'($urandom_range(254)));
            case ($urandom_range(2))
              0: push_byte(8'h00);
              1: push_byte(8'(LengthLimit));
              default: push_byte(8'($urandom_range(LengthLimit, 255)));
            endcase
          end
          default: begin
            // frame cut short, later bytes fall into its payload
            len = $urandom_range(4, 8);
            push_byte(Sync1Byte);
            push_byte(Sync2Byte);
            push_byte(8'($urandom_range(254)));
            push_byte(8'(len));
            repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom_range(255)));
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_enable(1'b1);

    // directed: FF FF does not restart, then a zero length aborts
    push_byte(Sync1Byte);
    push_byte(Sync1Byte);
    push_byte(Sync1Byte);
    push_byte(Sync2Byte);
    push_byte(8'h01);
    push_byte(8'h00);
    // short payload with a bad checksum reports the mismatch
    queue_frame(8'h02, 1, 32'hAA00_0000, 1'b1);
    // short payload with a good checksum
    queue_frame(8'h03, 2, 32'h1122_0000, 1'b0);
    // long payload, highest id, x at its negative corner and y at its top
    queue_frame(8'hFE, 5, 32'h8000_7FFF, 1'b0);
    settle();

    // sums off, sender idles often
    write_enable(1'b0);
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    random_traffic(BytesPerPhase);
    settle();

    // sums on, receiver stalls often
    write_enable(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    random_traffic(BytesPerPhase);
    settle();

    // light idling both ways with a long receiver hold-off to back up the input
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    hold_armed     = 1'b1;
    random_traffic(BytesPerPhase);
    settle();

    // sums off again, full rate
    write_enable(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(BytesPerPhase);
    settle();

    if (err_count == 0) begin
      $display("sync_length_checksum_frame_parser_tb OK");
    end else begin
      $display("sync_length_checksum_frame_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
